>>> rtl/vsd_pkg.sv
// ----------------------------------------------------------------------------
// Vertical diffusion stencil package
// Shared widths, register indexes and the types that pass between modules.
// ----------------------------------------------------------------------------
package vsd_pkg;

  // Data format: unsigned or signed Q(DataWidth-FracBits).FracBits
  localparam int unsigned DataWidth = 32;
  localparam int unsigned FracBits  = 16;

  // Divider: numerator is a DataWidth-bit magnitude shifted up by FracBits
  localparam int unsigned DivBits          = DataWidth + FracBits;
  localparam int unsigned DivStepsPerCycle = 2;
  localparam int unsigned DivCycles        =
      (DivBits + DivStepsPerCycle - 1) / DivStepsPerCycle;
  localparam int unsigned DivPadBits       = DivCycles * DivStepsPerCycle;
  localparam int unsigned DivCntWidth      = $clog2(DivCycles + 1);

  // Configuration register indexes
  localparam int unsigned CfgIdxWidth = 1;
  localparam logic [CfgIdxWidth-1:0] CfgUseVariable = CfgIdxWidth'(0);
  localparam logic [CfgIdxWidth-1:0] CfgDefaultK    = CfgIdxWidth'(1);

  typedef logic [DataWidth-1:0] data_t;

  localparam data_t DataMax = '1;
  localparam data_t SignMin = {1'b1, {(DataWidth-1){1'b0}}};
  localparam data_t PosMax  = {1'b0, {(DataWidth-1){1'b1}}};

  // Divider request: quotient = num * 2^FracBits / den
  typedef struct packed {
    logic  start;
    data_t num;
    data_t den;
  } div_req_t;

  // Divider response: quotient saturated to DataMax, clip flags saturation
  typedef struct packed {
    logic  done;
    data_t quo;
    logic  clip;
  } div_rsp_t;

  typedef struct packed {
    data_t tendency;
    logic  saturated;
    logic  last_level;
  } result_t;

endpackage

>>> rtl/vertical_scalar_diffusion_stencil.sv
// ----------------------------------------------------------------------------
// Vertical scalar diffusion stencil
// Three-point variable-coefficient diffusion over a column, one level per
// transfer, sign-magnitude fixed point with saturation.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+----------------------------
//  in       | sink      | in_valid_i / in_stall_o | value, diffusivity, invalid,
//           |           |                         | spacing, column_end
//  out      | source    | out_valid_o/out_stall_i | tendency, saturated,
//           |           |                         | last_level
//  cfg      | sink      | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
//  Sequencing: a top, second or single level is finished on arrival. An interior
//  level takes three passes through the shared 2-bit-per-cycle divider, and one
//  more step at a column's end.
//  Reset: asynchronous, active low; clears configuration, window and queue.
//  Stalls: results wait in a four-entry queue; a new level is taken whenever
//  the sequencer is idle and the queue has room for two results.
// ----------------------------------------------------------------------------
module vertical_scalar_diffusion_stencil (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [vsd_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [vsd_pkg::DataWidth-1:0]       cfg_wdata_i,
  // level input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [vsd_pkg::DataWidth-1:0] value_i,
  input  logic signed [vsd_pkg::DataWidth-1:0] diffusivity_i,
  input  logic                                diffusivity_invalid_i,
  input  logic [vsd_pkg::DataWidth-1:0]       spacing_i,
  input  logic                                column_end_i,
  // tendency output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [vsd_pkg::DataWidth-1:0] tendency_o,
  output logic                                saturated_o,
  output logic                                last_level_o
);

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrWidth  = $clog2(FifoDepth);
  localparam int unsigned CntWidth  = $clog2(FifoDepth + 1);
  localparam logic [1:0]  LevelsFull = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StDivU,
    StDivD,
    StMulU,
    StSclU,
    StMulD,
    StSclD,
    StNet,
    StDivT,
    StLast
  } state_e;

  state_e state_q;

  // configuration registers
  logic           use_var_q;
  vsd_pkg::data_t default_k_q;

  // window: entry 0 is two levels up, entry 1 the level just above
  vsd_pkg::data_t val_win_q [2];
  vsd_pkg::data_t k_win_q   [2];
  vsd_pkg::data_t sp_win_q  [2];
  logic [1:0]     levels_q;

  // level under work
  vsd_pkg::data_t v_new_q, k_new_q, s_new_q;
  logic           last_q;

  // intermediate results
  vsd_pkg::data_t gu_q, gd_q, fu_q, fd_q;
  logic [2*vsd_pkg::DataWidth-1:0] prod_q, prod_d;
  logic           nn_q, clip_q;

  // result queue
  vsd_pkg::result_t fifo_q [FifoDepth];
  logic [PtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0] count_q;
  logic               push, pop;
  vsd_pkg::result_t   push_data;

  logic           in_acc;
  vsd_pkg::data_t k_eff, s_eff;
  logic [vsd_pkg::DataWidth:0] du, dd;
  vsd_pkg::data_t kavg_u, kavg_d, mul_a, mul_b;
  vsd_pkg::data_t fscaled;
  logic           fclip;
  vsd_pkg::data_t net;
  logic           net_clip, nn_d;
  vsd_pkg::data_t tend;
  logic           tend_clip;
  logic           win_upd;
  vsd_pkg::data_t win_v, win_k, win_s;
  logic           win_last;

  vsd_pkg::div_req_t div_req;
  vsd_pkg::div_rsp_t div_rsp;

  // a - b of two signed values as {negative, magnitude}
  function automatic logic [vsd_pkg::DataWidth:0] sdiff(vsd_pkg::data_t a,
                                                        vsd_pkg::data_t b);
    logic [vsd_pkg::DataWidth:0] d;
    d = {a[vsd_pkg::DataWidth-1], a} - {b[vsd_pkg::DataWidth-1], b};
    if (d[vsd_pkg::DataWidth]) begin
      d = -d;
      return {1'b1, d[vsd_pkg::DataWidth-1:0]};
    end
    return {1'b0, d[vsd_pkg::DataWidth-1:0]};
  endfunction

  // floor of the mean without overflow
  function automatic vsd_pkg::data_t kavg(vsd_pkg::data_t a, vsd_pkg::data_t b);
    return (a >> 1) + (b >> 1) + vsd_pkg::DataWidth'(a[0] & b[0]);
  endfunction

  assign in_stall_o = (state_q != StIdle) ||
                      (count_q > CntWidth'(FifoDepth - 2));
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_var_q   <= 1'b0;
      default_k_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        vsd_pkg::CfgUseVariable: use_var_q   <= cfg_wdata_i[0];
        vsd_pkg::CfgDefaultK:    default_k_q <= cfg_wdata_i;
      endcase
    end
  end

  // ---- fix the level's diffusivity and spacing on arrival ----
  always_comb begin
    if (!use_var_q || diffusivity_invalid_i) begin
      k_eff = default_k_q;
    end else if (diffusivity_i[vsd_pkg::DataWidth-1]) begin
      k_eff = '0;
    end else begin
      k_eff = $unsigned(diffusivity_i);
    end
    s_eff = (spacing_i == '0) ? vsd_pkg::DataWidth'(1) : spacing_i;
  end

  // ---- datapath around the shared divider ----
  assign du     = sdiff(val_win_q[1], val_win_q[0]);
  assign dd     = sdiff(v_new_q, val_win_q[1]);
  assign kavg_u = kavg(k_win_q[1], k_win_q[0]);
  assign kavg_d = kavg(k_win_q[1], k_new_q);

  // one multiplier, shared by both fluxes
  assign mul_a  = (state_q == StMulU) ? kavg_u : kavg_d;
  assign mul_b  = (state_q == StMulU) ? gu_q : gd_q;
  assign prod_d = (2*vsd_pkg::DataWidth)'(mul_a) * (2*vsd_pkg::DataWidth)'(mul_b);

  // drop the fraction of the flux, saturate the magnitude
  assign fclip   = |prod_q[2*vsd_pkg::DataWidth-1:vsd_pkg::DataWidth+vsd_pkg::FracBits];
  assign fscaled = fclip ? vsd_pkg::DataMax
                         : prod_q[vsd_pkg::DataWidth+vsd_pkg::FracBits-1:vsd_pkg::FracBits];

  // net flux, sign and magnitude
  always_comb begin
    logic [vsd_pkg::DataWidth:0] sum;
    sum      = {1'b0, fd_q} + {1'b0, fu_q};
    net_clip = 1'b0;
    if (dd[vsd_pkg::DataWidth] != du[vsd_pkg::DataWidth]) begin
      nn_d     = dd[vsd_pkg::DataWidth];
      net_clip = sum[vsd_pkg::DataWidth];
      net      = sum[vsd_pkg::DataWidth] ? vsd_pkg::DataMax : sum[vsd_pkg::DataWidth-1:0];
    end else if (fd_q >= fu_q) begin
      nn_d = dd[vsd_pkg::DataWidth];
      net  = fd_q - fu_q;
    end else begin
      nn_d = !dd[vsd_pkg::DataWidth];
      net  = fu_q - fd_q;
    end
  end

  // signed saturation of the final quotient
  always_comb begin
    vsd_pkg::data_t t;
    t         = div_rsp.quo;
    tend_clip = 1'b0;
    if (nn_q) begin
      if (t > vsd_pkg::SignMin) begin
        t         = vsd_pkg::SignMin;
        tend_clip = 1'b1;
      end
      tend = -t;
    end else begin
      if (t > vsd_pkg::PosMax) begin
        t         = vsd_pkg::PosMax;
        tend_clip = 1'b1;
      end
      tend = t;
    end
  end

  // divider requests: upper gradient on arrival, lower gradient, tendency
  always_comb begin
    div_req = '0;
    unique case (state_q)
      StIdle: begin
        div_req.start = in_acc && (levels_q == LevelsFull);
        div_req.num   = du[vsd_pkg::DataWidth-1:0];
        div_req.den   = sp_win_q[0];
      end
      StDivU: begin
        div_req.start = div_rsp.done;
        div_req.num   = dd[vsd_pkg::DataWidth-1:0];
        div_req.den   = s_new_q;
      end
      StNet: begin
        div_req.start = 1'b1;
        div_req.num   = net;
        div_req.den   = sp_win_q[1];
      end
      default: ;
    endcase
  end

  vsd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---- results and window advance ----
  always_comb begin
    push      = 1'b0;
    push_data = '0;
    win_upd   = 1'b0;
    win_v     = v_new_q;
    win_k     = k_new_q;
    win_s     = s_new_q;
    win_last  = last_q;
    unique case (state_q)
      StIdle: begin
        // top level always gives zero; second level only at a column end
        win_v    = $unsigned(value_i);
        win_k    = k_eff;
        win_s    = s_eff;
        win_last = column_end_i;
        if (in_acc && (levels_q != LevelsFull)) begin
          win_upd              = 1'b1;
          push                 = (levels_q == 2'd0) || column_end_i;
          push_data.last_level = column_end_i;
        end
      end
      StDivT: begin
        if (div_rsp.done) begin
          push               = 1'b1;
          push_data.tendency = tend;
          push_data.saturated = clip_q || div_rsp.clip || tend_clip;
          win_upd            = !last_q;
        end
      end
      StLast: begin
        push                 = 1'b1;
        push_data.last_level = 1'b1;
        win_upd              = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_win_q <= '{default: '0};
      k_win_q   <= '{default: '0};
      sp_win_q  <= '{default: '0};
      levels_q  <= '0;
    end else if (win_upd) begin
      val_win_q[0] <= val_win_q[1];
      k_win_q[0]   <= k_win_q[1];
      sp_win_q[0]  <= sp_win_q[1];
      val_win_q[1] <= win_v;
      k_win_q[1]   <= win_k;
      sp_win_q[1]  <= win_s;
      // restart the column after its last level, else count up to full
      if (win_last) begin
        levels_q <= '0;
      end else if (levels_q != LevelsFull) begin
        levels_q <= levels_q + 2'd1;
      end
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle: if (in_acc && (levels_q == LevelsFull)) state_q <= StDivU;
        StDivU: if (div_rsp.done) state_q <= StDivD;
        StDivD: if (div_rsp.done) state_q <= StMulU;
        StMulU: state_q <= StSclU;
        StSclU: state_q <= StMulD;
        StMulD: state_q <= StSclD;
        StSclD: state_q <= StNet;
        StNet:  state_q <= StDivT;
        StDivT: begin
          if (div_rsp.done) state_q <= last_q ? StLast : StIdle;
        end
        StLast: state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  // intermediate values, held between sequencer steps
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          v_new_q <= $unsigned(value_i);
          k_new_q <= k_eff;
          s_new_q <= s_eff;
          last_q  <= column_end_i;
          clip_q  <= 1'b0;
        end
      end
      StDivU: begin
        if (div_rsp.done) begin
          gu_q   <= div_rsp.quo;
          clip_q <= clip_q | div_rsp.clip;
        end
      end
      StDivD: begin
        if (div_rsp.done) begin
          gd_q   <= div_rsp.quo;
          clip_q <= clip_q | div_rsp.clip;
        end
      end
      StMulU, StMulD: prod_q <= prod_d;
      StSclU: begin
        fu_q   <= fscaled;
        clip_q <= clip_q | fclip;
      end
      StSclD: begin
        fd_q   <= fscaled;
        clip_q <= clip_q | fclip;
      end
      StNet: begin
        nn_q   <= nn_d;
        clip_q <= clip_q | net_clip;
      end
      default: ;
    endcase
  end

  // ---- result queue ----
  assign pop = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= push_data;
  end

  assign out_valid_o  = (count_q != '0);
  assign tendency_o   = $signed(fifo_q[rd_ptr_q].tendency);
  assign saturated_o  = fifo_q[rd_ptr_q].saturated;
  assign last_level_o = fifo_q[rd_ptr_q].last_level;

  // ---- assertions ----
  a_fifo_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (count_q != CntWidth'(FifoDepth)) || pop)
    else $error("result queue overflow");

  a_div_done_awaited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == StDivU || state_q == StDivD || state_q == StDivT))
    else $error("divider result arrived with no step waiting for it");

  a_last_after_tendency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLast) |-> ($past(state_q) == StDivT) && last_q)
    else $error("column end zero issued out of order");

endmodule

>>> rtl/vsd_div.sv
// ----------------------------------------------------------------------------
// Shared fixed-point divider
// Restoring division, two quotient bits per cycle, saturating quotient.
// ----------------------------------------------------------------------------
module vsd_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vsd_pkg::div_req_t req_i,
  output vsd_pkg::div_rsp_t rsp_o
);

  logic [vsd_pkg::DivPadBits-1:0]  num_q, num_d;
  logic [vsd_pkg::DivPadBits-1:0]  quo_q, quo_d;
  vsd_pkg::data_t                  rem_q, rem_d;
  vsd_pkg::data_t                  den_q;
  logic [vsd_pkg::DivCntWidth-1:0] cnt_q;
  logic                            busy_q, done_q;
  logic                            overflow;

  // two dependent restoring steps per cycle
  always_comb begin
    logic [vsd_pkg::DataWidth:0] trial;
    num_d = num_q;
    quo_d = quo_q;
    rem_d = rem_q;
    trial = '0;
    for (int i = 0; i < vsd_pkg::DivStepsPerCycle; i++) begin
      trial = {rem_d, num_d[vsd_pkg::DivPadBits-1]};
      num_d = num_d << 1;
      if (trial >= {1'b0, den_q}) begin
        trial = trial - {1'b0, den_q};
        quo_d = {quo_d[vsd_pkg::DivPadBits-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[vsd_pkg::DivPadBits-2:0], 1'b0};
      end
      rem_d = trial[vsd_pkg::DataWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= vsd_pkg::DivCntWidth'(vsd_pkg::DivCycles);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == vsd_pkg::DivCntWidth'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath: no reset needed
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= vsd_pkg::DivPadBits'({req_i.num, {vsd_pkg::FracBits{1'b0}}});
      quo_q <= '0;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      num_q <= num_d;
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign overflow   = |quo_q[vsd_pkg::DivPadBits-1:vsd_pkg::DataWidth];
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = overflow ? vsd_pkg::DataMax : quo_q[vsd_pkg::DataWidth-1:0];
  assign rsp_o.clip = overflow;

endmodule

>>> test/tb_vertical_scalar_diffusion_stencil.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertical scalar diffusion stencil testbench
// Streams columns of levels through the stencil with random idling on both
// channels and checks every tendency, in order, against a fixed-point
// prediction kept in a scoreboard. The run covers both diffusivity modes, the
// default at its extremes, single- and two-level columns, clamped and invalid
// diffusivities, zero spacing and saturation.
// ----------------------------------------------------------------------------
module tb_vertical_scalar_diffusion_stencil;

  localparam logic [63:0] WordMask = 64'(vsd_pkg::DataMax);
  localparam logic [63:0] SignWord = 64'(vsd_pkg::SignMin);
  localparam logic [63:0] UnitFix  = 64'd1 << vsd_pkg::FracBits;

  // One level as it crosses the input channel
  typedef struct packed {
    vsd_pkg::data_t value;
    vsd_pkg::data_t diffusivity;
    logic           invalid;
    vsd_pkg::data_t spacing;
    logic           column_end;
  } level_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the window and the registers, predicts the tendencies
  // that each accepted level releases and checks them in order.
  // --------------------------------------------------------------------------
  class tendency_scoreboard;
    bit                 use_variable;
    logic [63:0]        default_k;
    logic signed [63:0] value_win[2];
    logic [63:0]        k_win[2];
    logic [63:0]        dz_win[2];
    int unsigned        depth;
    bit                 clipped;
    vsd_pkg::result_t   tendency_q[$];
    int unsigned        errors, levels, columns, checked, clip_count;

    function new();
      use_variable = 1'b0;
      default_k    = '0;
      value_win    = '{default: '0};
      k_win        = '{default: '0};
      dz_win       = '{default: '0};
      depth        = 0;
    endfunction

    function void write_register(logic [vsd_pkg::CfgIdxWidth-1:0] idx,
                                 vsd_pkg::data_t wdata);
      case (idx)
        vsd_pkg::CfgUseVariable: use_variable = wdata[0];
        vsd_pkg::CfgDefaultK:    default_k    = 64'(wdata);
        default: ;
      endcase
    endfunction

    // a*b/c truncated, clipped to the word range
    function logic [63:0] scale_div(logic [63:0] a, logic [63:0] b, logic [63:0] c);
      logic [127:0] q;
      q = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
      if (q > 128'(WordMask)) begin
        clipped = 1'b1;
        return WordMask;
      end
      return q[63:0];
    endfunction

    function logic [63:0] mean_k(logic [63:0] a, logic [63:0] b);
      return (a >> 1) + (b >> 1) + (a & b & 64'd1);
    endfunction

    // Interior tendency of the middle level, given the level below it
    function vsd_pkg::data_t interior(logic signed [63:0] v_new, logic [63:0] k_new,
                                      logic [63:0] dz_new);
      bit          neg_up, neg_dn, neg_net;
      logic [63:0] d_up, d_dn, g_up, g_dn, f_up, f_dn, net, t;
      neg_up = value_win[1] < value_win[0];
      d_up   = neg_up ? value_win[0] - value_win[1] : value_win[1] - value_win[0];
      neg_dn = v_new < value_win[1];
      d_dn   = neg_dn ? value_win[1] - v_new : v_new - value_win[1];
      g_up   = scale_div(d_up, UnitFix, dz_win[0]);
      g_dn   = scale_div(d_dn, UnitFix, dz_new);
      f_up   = scale_div(mean_k(k_win[1], k_win[0]), g_up, UnitFix);
      f_dn   = scale_div(mean_k(k_win[1], k_new), g_dn, UnitFix);
      // Combine the two fluxes in sign-magnitude form
      if (neg_dn != neg_up) begin
        neg_net = neg_dn;
        net     = f_dn + f_up;
        if (net > WordMask) begin
          clipped = 1'b1;
          net     = WordMask;
        end
      end else if (f_dn >= f_up) begin
        neg_net = neg_dn;
        net     = f_dn - f_up;
      end else begin
        neg_net = !neg_dn;
        net     = f_up - f_dn;
      end
      t = scale_div(net, UnitFix, dz_win[1]);
      if (neg_net) begin
        if (t > SignWord) begin
          clipped = 1'b1;
          t       = SignWord;
        end
        return vsd_pkg::data_t'(64'd0 - t);
      end
      if (t > SignWord - 1) begin
        clipped = 1'b1;
        t       = SignWord - 1;
      end
      return vsd_pkg::data_t'(t);
    endfunction

    // Note an accepted level: queue the tendencies it releases, advance window
    function void note_level(level_t lv);
      logic signed [63:0] v;
      logic [63:0]        k, dz;
      vsd_pkg::data_t     t;
      v  = {{(64-vsd_pkg::DataWidth){lv.value[vsd_pkg::DataWidth-1]}}, lv.value};
      if (!use_variable || lv.invalid) k = default_k;
      else if (lv.diffusivity[vsd_pkg::DataWidth-1]) k = '0;
      else k = 64'(lv.diffusivity);
      dz = (lv.spacing == '0) ? 64'd1 : 64'(lv.spacing);
      levels++;
      if (depth == 0) begin
        tendency_q.push_back(vsd_pkg::result_t'{tendency: '0, saturated: 1'b0,
                                                last_level: lv.column_end});
      end else begin
        if (depth >= 2) begin
          clipped = 1'b0;
          t = interior(v, k, dz);
          tendency_q.push_back(vsd_pkg::result_t'{tendency: t, saturated: clipped,
                                                  last_level: 1'b0});
        end
        if (lv.column_end)
          tendency_q.push_back(vsd_pkg::result_t'{tendency: '0, saturated: 1'b0,
                                                  last_level: 1'b1});
      end
      value_win[0] = value_win[1];
      k_win[0]     = k_win[1];
      dz_win[0]    = dz_win[1];
      value_win[1] = v;
      k_win[1]     = k;
      dz_win[1]    = dz;
      if (lv.column_end) begin
        depth = 0;
        columns++;
      end else if (depth < 2) begin
        depth++;
      end
    endfunction

    function void check_result(vsd_pkg::data_t tendency, logic saturated,
                               logic last_level);
      vsd_pkg::result_t exp_r;
      if (tendency_q.size() == 0) begin
        $error("tendency %h arrived with none expected", tendency);
        errors++;
        return;
      end
      exp_r = tendency_q.pop_front();
      checked++;
      if (saturated) clip_count++;
      if (tendency !== exp_r.tendency) begin
        $error("tendency: expected %h, got %h", exp_r.tendency, tendency);
        errors++;
      end
      if (saturated !== exp_r.saturated) begin
        $error("saturated: expected %b, got %b", exp_r.saturated, saturated);
        errors++;
      end
      if (last_level !== exp_r.last_level) begin
        $error("last_level: expected %b, got %b", exp_r.last_level, last_level);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return tendency_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                            cfg_we_i              = 1'b0;
  logic [vsd_pkg::CfgIdxWidth-1:0] cfg_index_i           = vsd_pkg::CfgUseVariable;
  vsd_pkg::data_t                  cfg_wdata_i           = '0;
  logic                            in_valid_i            = 1'b0;
  logic                            in_stall_o;
  vsd_pkg::data_t                  value_i               = '0;
  vsd_pkg::data_t                  diffusivity_i         = '0;
  logic                            diffusivity_invalid_i = 1'b0;
  vsd_pkg::data_t                  spacing_i             = '0;
  logic                            column_end_i          = 1'b0;
  logic                            out_valid_o;
  logic                            out_stall_i           = 1'b0;
  vsd_pkg::data_t                  tendency_o;
  logic                            saturated_o;
  logic                            last_level_o;

  // Cleared for the quiet phase so both channels run flat out
  bit          idle_enable = 1'b1;
  int unsigned settings    = 0;

  tendency_scoreboard sb = new();

  always #6 clk_i = ~clk_i;

  vertical_scalar_diffusion_stencil dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .value_i,
    .diffusivity_i,
    .diffusivity_invalid_i,
    .spacing_i,
    .column_end_i,
    .out_valid_o,
    .out_stall_i,
    .tendency_o,
    .saturated_o,
    .last_level_o
  );

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------

  // Offer one level, possibly after a random idle gap, and hold it until the
  // transfer happens. Valid stays high on return so back-to-back levels flow.
  task automatic send_level(level_t lv);
    while (idle_enable && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    value_i               <= lv.value;
    diffusivity_i         <= lv.diffusivity;
    diffusivity_invalid_i <= lv.invalid;
    spacing_i             <= lv.spacing;
    column_end_i          <= lv.column_end;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_level(lv);
  endtask

  // Drop valid and wait until every tendency is in, then allow the block to
  // finish a level that releases nothing before the registers change.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Write both registers; junk in the upper bits of the mode word checks the
  // masking of the one-bit register.
  task automatic write_config(bit use_variable, vsd_pkg::data_t dflt);
    vsd_pkg::data_t word;
    word        = $urandom;
    word[0]     = use_variable;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= vsd_pkg::CfgUseVariable;
    cfg_wdata_i <= word;
    @(posedge clk_i);
    sb.write_register(vsd_pkg::CfgUseVariable, word);
    cfg_index_i <= vsd_pkg::CfgDefaultK;
    cfg_wdata_i <= dflt;
    @(posedge clk_i);
    sb.write_register(vsd_pkg::CfgDefaultK, dflt);
    cfg_we_i    <= 1'b0;
    settings++;
  endtask

  // Mostly moderate values so that many tendencies stay in range, with full
  // random words and the extremes mixed in.
  function automatic level_t random_level(bit last);
    level_t lv;
    case ($urandom_range(9))
      0:       lv.value = $urandom;
      1:       lv.value = $urandom_range(1) ? vsd_pkg::SignMin : vsd_pkg::PosMax;
      default: lv.value = vsd_pkg::data_t'($urandom_range(0, 32'h0008_0000))
                          - 32'h0004_0000;
    endcase
    case ($urandom_range(9))
      0:       lv.diffusivity = $urandom;
      1:       lv.diffusivity = -vsd_pkg::data_t'($urandom_range(1, 32'h0002_0000));
      2:       lv.diffusivity = $urandom_range(1) ? vsd_pkg::PosMax : '0;
      default: lv.diffusivity = $urandom_range(0, 32'h0004_0000);
    endcase
    case ($urandom_range(9))
      0:       lv.spacing = '0;
      1:       lv.spacing = $urandom;
      2:       lv.spacing = $urandom_range(1) ? vsd_pkg::DataMax : vsd_pkg::data_t'(1);
      default: lv.spacing = $urandom_range(32'h0000_4000, 32'h0004_0000);
    endcase
    lv.invalid    = $urandom_range(99) < 10;
    lv.column_end = last;
    return lv;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: check each transfer, stall at random
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        sb.check_result(tendency_o, saturated_o, last_level_o);
      out_stall_i <= idle_enable && ($urandom_range(99) < 27);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    level_t         directed[15];
    bit             use_variable;
    vsd_pkg::data_t dflt;
    int unsigned    sent, len;

    // Single level, a short column under reset settings, a two-level column,
    // then a long column through clamping, invalid flags, zero and maximal
    // spacing and saturation in both directions.
    directed = '{
      '{vsd_pkg::PosMax,  32'h0,           1'b0, 32'h0,            1'b1},
      '{32'h0001_0000,    32'h0001_0000,   1'b0, 32'h0001_0000,    1'b0},
      '{32'h0002_0000,    32'h0002_0000,   1'b0, 32'h0001_0000,    1'b0},
      '{32'h0,            32'h0001_0000,   1'b1, 32'h0001_0000,    1'b1},
      '{vsd_pkg::SignMin, 32'hFFFF_FFFF,   1'b0, 32'h0,            1'b0},
      '{vsd_pkg::PosMax,  vsd_pkg::PosMax, 1'b0, vsd_pkg::DataMax, 1'b1},
      '{32'h0,            32'h0001_0000,   1'b0, 32'h0001_0000,    1'b0},
      '{32'h0001_0000,    32'h0002_0000,   1'b0, 32'h0001_0000,    1'b0},
      '{32'h0003_0000,    vsd_pkg::SignMin, 1'b0, 32'h0001_0000,   1'b0},
      '{vsd_pkg::PosMax,  vsd_pkg::PosMax, 1'b1, 32'h0,            1'b0},
      '{vsd_pkg::SignMin, vsd_pkg::PosMax, 1'b0, 32'h0,            1'b0},
      '{vsd_pkg::SignMin, 32'h0001_0000,   1'b0, vsd_pkg::DataMax, 1'b0},
      '{32'h0,            32'h0,           1'b0, vsd_pkg::DataMax, 1'b0},
      '{32'hFFFF_0000,    32'h0000_8000,   1'b0, 32'h0000_4000,    1'b0},
      '{32'h0,            32'hFFFF_FFFF,   1'b1, 32'h0001_0000,    1'b1}
    };

    // Hold reset, then release it on a clock edge
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // First columns run with the registers as reset leaves them
    for (int i = 0; i < 4; i++) send_level(directed[i]);
    settle();
    write_config(1'b1, 32'h0001_8000);
    for (int i = 4; i < 15; i++) send_level(directed[i]);

    // Random phases, each under its own register setting
    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: begin use_variable = 1'b1; dflt = '0;               end
        1: begin use_variable = 1'b0; dflt = vsd_pkg::DataMax; end
        2: begin use_variable = 1'b1; dflt = vsd_pkg::DataMax; end
        3: begin use_variable = 1'b0; dflt = $urandom_range(0, 32'h0004_0000); end
        4: begin use_variable = 1'b1; dflt = $urandom; end
        5: begin use_variable = 1'b0; dflt = '0;               end
        6: begin use_variable = 1'b1; dflt = $urandom_range(0, 32'h0004_0000); end
        default: begin use_variable = 1'b0; dflt = $urandom; end
      endcase
      idle_enable = (p != 3);
      write_config(use_variable, dflt);
      sent = 0;
      while (sent < 200) begin
        // Mostly full columns, with single- and two-level ones mixed in
        case ($urandom_range(9))
          0:       len = 1;
          1:       len = 2;
          default: len = $urandom_range(3, 12);
        endcase
        for (int i = 0; i < len; i++) send_level(random_level(i == len - 1));
        sent += len;
      end
    end

    // Drain, then watch a while longer for stray tendencies
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Streamed %0d levels in %0d columns under %0d register settings.",
             sb.levels, sb.columns, settings);
    $display("Checked %0d tendencies, %0d of them clipped.", sb.checked, sb.clip_count);
    if (sb.errors == 0) begin
      $display("tb_vertical_scalar_diffusion_stencil passed");
    end else begin
      $display("tb_vertical_scalar_diffusion_stencil failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest expected run
  initial begin
    #9_600_000;
    $display("Timed out with %0d tendencies outstanding.", sb.pending());
    $display("tb_vertical_scalar_diffusion_stencil failed");
    $finish;
  end

endmodule
